### rtl/ast_pkg.sv
// Package for the array set table: sizes, codes and the cell command struct.
`default_nettype none
package ast_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned OUT_W    = 7;
  localparam int unsigned STAT_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE     = 2'd0,
    STAT_NOCHANGE = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic             search;
    logic             ins;
    logic             del;
    logic             clr;
    logic [IDX_W-1:0] ins_idx;
    logic [IDX_W-1:0] del_idx;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/ast_cell.sv
// One storage cell of the set: entry, occupancy, match flag and downward shift.
`default_nettype none
module ast_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [ast_pkg::IDX_W-1:0]     idx_i,
  input  wire ast_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic signed [ast_pkg::VAL_W-1:0] key_i,
  input  wire logic signed [ast_pkg::VAL_W-1:0] up_entry_i,
  input  wire logic                          up_valid_i,
  output logic signed [ast_pkg::VAL_W-1:0]   entry_o,
  output logic                               valid_o,
  output logic                               hit_o
);

  logic signed [ast_pkg::VAL_W-1:0] entry_q, entry_d;
  logic                             valid_q, valid_d;
  logic                             hit_q, hit_d;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    hit_d   = hit_q;
    if (ctrl_i.search) begin
      hit_d = valid_q && (entry_q == key_i);
    end
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
      entry_d = '0;
    end else if (ctrl_i.del && (idx_i >= ctrl_i.del_idx)) begin
      entry_d = up_entry_i;
      valid_d = up_valid_i;
    end else if (ctrl_i.ins && (idx_i == ctrl_i.ins_idx)) begin
      entry_d = key_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule
`default_nettype wire

### rtl/ast_hit_enc.sv
// Encoder that turns the one-hot cell match flags into a cell index.
`default_nettype none
module ast_hit_enc (
  input  wire logic [ast_pkg::CAPACITY-1:0] hit_i,
  output logic                              found_o,
  output logic [ast_pkg::IDX_W-1:0]         idx_o
);

  always_comb begin
    idx_o = '0;
    for (int unsigned i = 0; i < ast_pkg::CAPACITY; i++) begin
      if (hit_i[i]) begin
        idx_o = idx_o | ast_pkg::IDX_W'(i);
      end
    end
  end

  assign found_o = |hit_i;

endmodule
`default_nettype wire

### rtl/array_set_table.sv
// Top level of the array set table: control, count and the row of cells.
//
//  channel | dir | handshake             | words
//  in      | in  | in_valid_i/in_ready_o  | func_i, value_i
//  out     | out | out_valid_o/out_ready_i| found_o, position_o, count_o, status_o
//
// Each word passes three steps: accept, parallel compare in every cell,
// then encode the match and update the row of cells.
// The update waits while an earlier result still sits in the output register,
// so back-pressure stalls the update step; a new word is taken once it commits.
// Reset empties the set at once; no clearing pass is needed.
`default_nettype none
module array_set_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ast_pkg::FUNC_W-1:0]    func_i,
  input  wire logic signed [ast_pkg::VAL_W-1:0] value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               found_o,
  output logic [ast_pkg::OUT_W-1:0]          position_o,
  output logic [ast_pkg::OUT_W-1:0]          count_o,
  output logic [ast_pkg::STAT_W-1:0]         status_o
);

  ast_pkg::state_e                  state_q, state_d;
  ast_pkg::op_e                     op_q;
  logic signed [ast_pkg::VAL_W-1:0] key_q;
  logic [ast_pkg::CNT_W-1:0]        count_q, count_d;

  logic                             out_valid_q, out_valid_d;
  logic                             found_q;
  logic [ast_pkg::OUT_W-1:0]        position_q, count_out_q;
  ast_pkg::status_e                 status_q;

  logic                             found_d;
  logic [ast_pkg::OUT_W-1:0]        position_d;
  ast_pkg::status_e                 status_d;

  ast_pkg::cell_ctrl_t              ctrl;
  logic                             commit;
  logic                             full;
  logic                             hit_found;
  logic [ast_pkg::IDX_W-1:0]        hit_idx;

  logic signed [ast_pkg::VAL_W-1:0] cell_entry [ast_pkg::CAPACITY];
  logic                             cell_valid [ast_pkg::CAPACITY];
  logic [ast_pkg::CAPACITY-1:0]     cell_hit;

  assign in_ready_o = (state_q == ast_pkg::S_IDLE);
  assign commit     = (state_q == ast_pkg::S_UPDATE) && (!out_valid_q || out_ready_i);
  assign full       = (count_q >= ast_pkg::CNT_W'(ast_pkg::CAPACITY));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ast_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ast_pkg::S_SEARCH;
        end
      end
      ast_pkg::S_SEARCH: begin
        state_d = ast_pkg::S_UPDATE;
      end
      ast_pkg::S_UPDATE: begin
        if (commit) begin
          state_d = ast_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ast_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.search  = (state_q == ast_pkg::S_SEARCH);
    ctrl.ins_idx = count_q[ast_pkg::IDX_W-1:0];
    ctrl.del_idx = hit_idx;
    count_d      = count_q;
    found_d      = hit_found;
    position_d   = hit_found ? ast_pkg::OUT_W'(ast_pkg::CNT_W'(hit_idx) + 1'b1)
                             : ast_pkg::OUT_W'(count_q);
    status_d     = ast_pkg::STAT_DONE;
    case (op_q)
      ast_pkg::OP_INSERT: begin
        if (hit_found) begin
          status_d = ast_pkg::STAT_NOCHANGE;
        end else if (full) begin
          status_d = ast_pkg::STAT_FULL;
        end else begin
          ctrl.ins = commit;
          count_d  = count_q + 1'b1;
        end
      end
      ast_pkg::OP_DELETE: begin
        if (!hit_found) begin
          status_d = ast_pkg::STAT_NOCHANGE;
        end else begin
          ctrl.del = commit;
          count_d  = count_q - 1'b1;
        end
      end
      ast_pkg::OP_QUERY: begin
        status_d = ast_pkg::STAT_DONE;
      end
      ast_pkg::OP_CLEAR: begin
        ctrl.clr   = commit;
        count_d    = '0;
        found_d    = 1'b0;
        position_d = '0;
      end
      default: begin
        status_d = ast_pkg::STAT_DONE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ast_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= ast_pkg::op_e'(func_i);
      key_q <= value_i;
    end
    if (commit) begin
      found_q     <= found_d;
      position_q  <= position_d;
      count_out_q <= ast_pkg::OUT_W'(count_d);
      status_q    <= status_d;
    end
  end

  for (genvar i = 0; i < ast_pkg::CAPACITY; i++) begin : g_cell
    logic signed [ast_pkg::VAL_W-1:0] up_entry;
    logic                             up_valid;
    if (i + 1 < ast_pkg::CAPACITY) begin : g_mid
      assign up_entry = cell_entry[i+1];
      assign up_valid = cell_valid[i+1];
    end else begin : g_top
      assign up_entry = '0;
      assign up_valid = 1'b0;
    end
    ast_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (ast_pkg::IDX_W'(i)),
      .ctrl_i     (ctrl),
      .key_i      (key_q),
      .up_entry_i (up_entry),
      .up_valid_i (up_valid),
      .entry_o    (cell_entry[i]),
      .valid_o    (cell_valid[i]),
      .hit_o      (cell_hit[i])
    );
  end

  ast_hit_enc u_enc (
    .hit_i   (cell_hit),
    .found_o (hit_found),
    .idx_o   (hit_idx)
  );

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = position_q;
  assign count_o     = count_out_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire

### rtl/ast_checker.sv
// Port-level checker for the array set table, bound to the top level.
`default_nettype none
module ast_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic                          found_o,
  input wire logic [ast_pkg::OUT_W-1:0]     position_o,
  input wire logic [ast_pkg::OUT_W-1:0]     count_o,
  input wire logic [ast_pkg::STAT_W-1:0]    status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_o) && $stable(count_o)
      && $stable(status_o) && $stable(found_o))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in work");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ast_pkg::STAT_FULL |->
      !found_o && count_o == ast_pkg::OUT_W'(ast_pkg::CAPACITY))
    else $error("full refusal with wrong count or match");

  a_absent_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o && status_o != ast_pkg::STAT_DONE |-> position_o == count_o)
    else $error("absent value position differs from count");

endmodule

bind array_set_table ast_checker u_ast_checker (.*);
`default_nettype wire
